FILE: sv/ghalloc_pkg.sv
package ghalloc_pkg;

    // Fixed field widths of the stream transactions.
    localparam int OPC_W      = 2;
    localparam int IN_IDX_W   = 12;
    localparam int GEN_W      = 32;
    localparam int OUT_IDX_W  = 10;
    localparam int STAT_W     = 2;
    localparam int LIVE_W     = 11;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 56;

    localparam int SLOT_COUNT_DEF = 1024;

    typedef enum logic [OPC_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_STALE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_REVIVE,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

FILE: sv/ghalloc_ram.sv
module ghalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/generational_handle_allocator.sv
// A result is registered from ST_DONE once the output register is free. Fresh creates,
// full creates, out-of-range handles and no-ops go from ST_IDLE straight to ST_DONE;
// destroy and query of an in-range handle pass through ST_CHECK, and a create that
// recycles a slot through ST_POP and ST_REVIVE. A new operation is taken only in ST_IDLE,
// as the sequencer walks the free-stack read and the generation-table read-modify-write
// one step at a time. Reset clears the counters and the sequencer; no memory clearing pass.
module generational_handle_allocator #(
    parameter int SLOT_COUNT = ghalloc_pkg::SLOT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input transaction.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, from bit 0: slot_index[11:0], handle_generation[43:12], zero pad [47:44].
    input  logic [ghalloc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [ghalloc_pkg::OPC_W-1:0]     s_axis_tuser,
    // Result transaction.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, from bit 0: out_index[9:0], out_generation[41:10], handle_alive[42],
    // status[44:43], live_count[55:45].
    output logic [ghalloc_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    import ghalloc_pkg::*;

    // Slot index width, and a counter width that can hold SLOT_COUNT itself.
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

    // The generation table holds {alive, generation} per slot. An entry is only
    // ever read below the high-water mark, and every slot below that mark was
    // written when it was first handed out, so the table needs no clearing.
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_free_top;
    logic [CNT_W-1:0]    r_high_water;
    logic [CNT_W-1:0]    r_live;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    // Operation context, held while the sequencer runs.
    t_opcode             r_op;
    logic [IDX_W-1:0]    r_idx;
    logic [GEN_W-1:0]    r_hgen;
    logic [IDX_W-1:0]    r_slot;

    // Result fields, completed by the time the sequencer reaches ST_DONE.
    logic [OUT_IDX_W-1:0] r_res_index;
    logic [GEN_W-1:0]     r_res_gen;
    logic                 r_res_alive;
    t_status              r_res_status;

    // Memory ports.
    logic                gen_we;
    logic [IDX_W-1:0]    gen_waddr;
    logic [GEN_W:0]      gen_wdata;
    logic [IDX_W-1:0]    gen_raddr;
    logic [GEN_W:0]      gen_rdata;
    logic                stk_we;
    logic [IDX_W-1:0]    stk_waddr;
    logic [IDX_W-1:0]    stk_raddr;
    logic [IDX_W-1:0]    stk_rdata;

    // Decoded input and status terms.
    t_opcode             in_op;
    logic [CMP_W-1:0]    in_idx_ext;
    logic [IDX_W-1:0]    in_addr;
    logic [GEN_W-1:0]    in_gen;
    logic                in_range;
    logic                s_accept;
    logic                free_avail;
    logic                fresh_avail;
    logic                stack_room;
    logic [CNT_W-1:0]    free_top_dec;
    logic                out_free;
    logic                rd_alive;
    logic [GEN_W-1:0]    rd_gen;
    logic                check_live;

    assign in_op       = t_opcode'(s_axis_tuser);
    assign in_idx_ext  = CMP_W'(s_axis_tdata[IN_IDX_W-1:0]);
    assign in_addr     = in_idx_ext[IDX_W-1:0];
    assign in_gen      = s_axis_tdata[IN_IDX_W +: GEN_W];
    assign in_range    = in_idx_ext < CMP_W'(r_high_water);
    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign free_avail  = r_free_top != '0;
    assign fresh_avail = r_high_water != CNT_W'(SLOT_COUNT);
    assign stack_room  = r_free_top != CNT_W'(SLOT_COUNT);
    assign free_top_dec = r_free_top - CNT_W'(1);
    assign out_free    = !r_out_valid || m_axis_tready;
    assign rd_alive    = gen_rdata[GEN_W];
    assign rd_gen      = gen_rdata[GEN_W-1:0];
    // Only meaningful in ST_CHECK, where the handle is known to be in range.
    assign check_live  = rd_alive && (rd_gen == r_hgen);

    ghalloc_ram #(
        .WIDTH (GEN_W + 1),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    ghalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_idx),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (in_op)
                        OP_CREATE:  n_state = free_avail ? ST_POP : ST_DONE;
                        OP_DESTROY,
                        OP_QUERY:   n_state = in_range ? ST_CHECK : ST_DONE;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_POP:    n_state = ST_REVIVE;
            ST_REVIVE: n_state = ST_DONE;
            ST_CHECK:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: the input handshake and the memory port controls.
    always_comb begin
        s_axis_tready = 1'b0;
        gen_we        = 1'b0;
        gen_waddr     = r_idx;
        gen_wdata     = {1'b0, rd_gen + GEN_W'(1)};
        gen_raddr     = in_addr;
        stk_we        = 1'b0;
        stk_waddr     = r_free_top[IDX_W-1:0];
        stk_raddr     = free_top_dec[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                // A fresh slot starts alive at generation 1.
                if (s_axis_tvalid && in_op == OP_CREATE && !free_avail && fresh_avail) begin
                    gen_we    = 1'b1;
                    gen_waddr = r_high_water[IDX_W-1:0];
                    gen_wdata = {1'b1, GEN_W'(1)};
                end
            end
            ST_POP: begin
                // The popped slot index comes straight from the stack read.
                gen_raddr = stk_rdata;
            end
            ST_REVIVE: begin
                // A recycled slot keeps the generation it got on destroy.
                gen_we    = 1'b1;
                gen_waddr = r_slot;
                gen_wdata = {1'b1, rd_gen};
            end
            ST_CHECK: begin
                if (r_op == OP_DESTROY && check_live) begin
                    gen_we = 1'b1;
                    stk_we = stack_room;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_top   <= '0;
            r_high_water <= '0;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept && in_op == OP_CREATE) begin
                if (free_avail) begin
                    r_free_top <= free_top_dec;
                end else if (fresh_avail) begin
                    r_high_water <= r_high_water + CNT_W'(1);
                    r_live       <= r_live + CNT_W'(1);
                end
            end
            if (r_state == ST_REVIVE) begin
                r_live <= r_live + CNT_W'(1);
            end
            if (r_state == ST_CHECK && r_op == OP_DESTROY && check_live) begin
                if (stack_room) begin
                    r_free_top <= r_free_top + CNT_W'(1);
                end
                if (r_live != '0) begin
                    r_live <= r_live - CNT_W'(1);
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation context and result payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op        <= in_op;
            r_idx       <= in_addr;
            r_hgen      <= in_gen;
            r_res_alive <= 1'b0;
            // A fresh create answers at once; a recycled one fills in at ST_REVIVE.
            if (in_op == OP_CREATE && !free_avail && fresh_avail) begin
                r_res_index <= OUT_IDX_W'(r_high_water);
                r_res_gen   <= GEN_W'(1);
            end else begin
                r_res_index <= '0;
                r_res_gen   <= '0;
            end
            if (in_op == OP_CREATE && !free_avail && !fresh_avail) begin
                r_res_status <= STAT_FULL;
            end else if (in_op == OP_DESTROY && !in_range) begin
                r_res_status <= STAT_STALE;
            end else begin
                r_res_status <= STAT_OK;
            end
        end
        if (r_state == ST_POP) begin
            r_slot <= stk_rdata;
        end
        if (r_state == ST_REVIVE) begin
            r_res_index <= OUT_IDX_W'(r_slot);
            r_res_gen   <= rd_gen;
        end
        if (r_state == ST_CHECK) begin
            r_res_alive <= check_live;
            if (r_op == OP_DESTROY && !check_live) begin
                r_res_status <= STAT_STALE;
            end
        end
        // The live count is already final once the sequencer reaches ST_DONE.
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= {LIVE_W'(r_live), r_res_status, r_res_alive, r_res_gen,
                           r_res_index};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Every slot below the high-water mark is either live or on the free stack.
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |->
            ({1'b0, r_free_top} + {1'b0, r_live}) == {1'b0, r_high_water})
        else $error("free stack and live count do not account for all slots");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_high_water)
        else $error("live count above high-water mark");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_we |-> (r_free_top < CNT_W'(SLOT_COUNT)))
        else $error("free stack push with the stack full");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == ST_DONE))
        else $error("result presented without a finished operation");

endmodule

FILE: sim/tb_top.sv
module tb_top;
    import ghalloc_pkg::*;

    localparam int NUM_SLOTS     = SLOT_COUNT_DEF;
    localparam int RANDOM_OPS    = 150;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    // Expected contents of one result transaction.
    typedef struct {
        logic [OUT_IDX_W-1:0] out_index;
        logic [GEN_W-1:0]     out_gen;
        logic                 alive;
        t_status              status;
        logic [LIVE_W-1:0]    live_count;
    } t_alloc_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [OPC_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;

    generational_handle_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the slot table, kept in step with accepted operations.
    logic [GEN_W-1:0]     slot_gen [NUM_SLOTS];
    logic                 slot_live [NUM_SLOTS];
    logic [OUT_IDX_W-1:0] recycle_stack [NUM_SLOTS];
    int unsigned          recycle_depth;
    int unsigned          fresh_mark;
    int unsigned          live_slots;

    t_alloc_reply awaited_replies [$];
    int           mismatches;
    bit           no_gaps;
    bit           rx_calm;
    bit           running;
    int           quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit handle_live(input logic [IN_IDX_W-1:0] idx,
                                       input logic [GEN_W-1:0] gen);
        if (idx >= fresh_mark || idx >= NUM_SLOTS)
            return 1'b0;
        return slot_live[idx] && slot_gen[idx] == gen;
    endfunction

    // Applies one operation to the shadow table and returns the reply it must give.
    function automatic t_alloc_reply predict_alloc_reply(input t_opcode op,
                                                         input logic [IN_IDX_W-1:0] idx,
                                                         input logic [GEN_W-1:0] gen);
        t_alloc_reply r;
        int unsigned  slot;
        bit           got;
        r.out_index = '0;
        r.out_gen   = '0;
        r.alive     = 1'b0;
        r.status    = STAT_OK;
        got         = 1'b0;
        slot        = 0;
        case (op)
            OP_CREATE: begin
                if (recycle_depth > 0) begin
                    recycle_depth--;
                    slot = recycle_stack[recycle_depth];
                    got  = 1'b1;
                end else if (fresh_mark < NUM_SLOTS) begin
                    slot = fresh_mark;
                    fresh_mark++;
                    slot_gen[slot] = 32'd1;
                    got = 1'b1;
                end
                if (got) begin
                    slot_live[slot] = 1'b1;
                    live_slots++;
                    r.out_index = slot[OUT_IDX_W-1:0];
                    r.out_gen   = slot_gen[slot];
                end else begin
                    r.status = STAT_FULL;
                end
            end
            OP_DESTROY: begin
                if (handle_live(idx, gen)) begin
                    slot_live[idx] = 1'b0;
                    slot_gen[idx]  = slot_gen[idx] + 32'd1;
                    if (recycle_depth < NUM_SLOTS) begin
                        recycle_stack[recycle_depth] = idx[OUT_IDX_W-1:0];
                        recycle_depth++;
                    end
                    if (live_slots > 0)
                        live_slots--;
                    r.alive = 1'b1;
                end else begin
                    r.status = STAT_STALE;
                end
            end
            OP_QUERY: begin
                r.alive = handle_live(idx, gen);
            end
            default: begin
            end
        endcase
        r.live_count = live_slots[LIVE_W-1:0];
        return r;
    endfunction

    // Presents one operation after a random gap and records its reply once accepted.
    // The valid is left high afterwards so back-to-back operations never toggle it.
    task automatic issue_op(input t_opcode op, input logic [IN_IDX_W-1:0] idx,
                            input logic [GEN_W-1:0] gen);
        int           gap;
        t_alloc_reply reply;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, gen, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        reply = predict_alloc_reply(op, idx, gen);
        awaited_replies = {awaited_replies, reply};
    endtask

    // Holds the sender off until every awaited reply has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_opcode any_opcode();
        return t_opcode'($urandom_range(0, 3));
    endfunction

    // Picks a handle: mostly a real one, sometimes an older or newer generation of it,
    // and sometimes something arbitrary across the whole index and generation range.
    task automatic pick_handle(output logic [IN_IDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
        int unsigned r;
        r   = $urandom_range(0, 99);
        idx = IN_IDX_W'($urandom_range(0, 4095));
        gen = $urandom;
        if (fresh_mark > 0 && r < 80) begin
            idx = IN_IDX_W'($urandom_range(0, fresh_mark - 1));
            gen = slot_gen[idx];
            if (r >= 60)
                gen = $urandom_range(0, 1) ? gen - 32'd1 : gen + 32'd1;
        end
    endtask

    task automatic test_basic_ops();
        issue_op(OP_CREATE, 12'd0, 32'd0);
        issue_op(OP_CREATE, 12'hFFF, 32'hFFFF_FFFF);
        issue_op(OP_QUERY, 12'd0, 32'd1);
        issue_op(OP_QUERY, 12'd0, 32'd0);
        issue_op(OP_QUERY, 12'd1, 32'hFFFF_FFFF);
        issue_op(OP_DESTROY, 12'd0, 32'd2);
        issue_op(OP_DESTROY, 12'd0, 32'd1);
        // A second destroy of the same handle is stale.
        issue_op(OP_DESTROY, 12'd0, 32'd1);
        issue_op(OP_QUERY, 12'd0, 32'd1);
        // Recycles slot zero with its raised generation.
        issue_op(OP_CREATE, 12'd0, 32'd0);
        issue_op(OP_QUERY, 12'd0, 32'd2);
        // Indices past the high-water mark and past the table are never live.
        issue_op(OP_QUERY, 12'd2, 32'd1);
        issue_op(OP_QUERY, 12'd1023, 32'd1);
        issue_op(OP_QUERY, 12'd1024, 32'd1);
        issue_op(OP_QUERY, 12'hFFF, 32'hFFFF_FFFF);
        issue_op(OP_DESTROY, 12'hFFF, 32'd1);
        issue_op(OP_DESTROY, 12'd1024, 32'd0);
        issue_op(OP_NOP, 12'hFFF, 32'hFFFF_FFFF);
        issue_op(OP_NOP, 12'd0, 32'd0);
        issue_op(OP_DESTROY, 12'd1, 32'd1);
        issue_op(OP_DESTROY, 12'd0, 32'd2);
    endtask

    // Fills every slot, asks for more, then frees them all in a shuffled order so
    // the recycle stack ends up at full depth.
    task automatic test_table_full();
        int unsigned order [NUM_SLOTS];
        int unsigned j;
        int unsigned tmp;
        no_gaps = 1'b1;
        while (live_slots < NUM_SLOTS)
            issue_op(OP_CREATE, IN_IDX_W'($urandom_range(0, 4095)), $urandom);
        no_gaps = 1'b0;
        issue_op(OP_CREATE, 12'd5, 32'd1);
        issue_op(OP_CREATE, 12'hFFF, 32'hFFFF_FFFF);
        issue_op(OP_QUERY, 12'd1023, slot_gen[1023]);
        issue_op(OP_QUERY, 12'd1024, 32'd1);
        for (int i = 0; i < NUM_SLOTS; i++)
            order[i] = i;
        for (int i = NUM_SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        no_gaps = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++)
            issue_op(OP_DESTROY, IN_IDX_W'(order[i]), slot_gen[order[i]]);
        no_gaps = 1'b0;
        issue_op(OP_DESTROY, IN_IDX_W'(order[0]), slot_gen[order[0]] - 32'd1);
        issue_op(OP_CREATE, 12'd0, 32'd0);
    endtask

    task automatic test_random_ops();
        logic [IN_IDX_W-1:0] idx;
        logic [GEN_W-1:0]    gen;
        int unsigned         r;
        int unsigned         create_weight;
        t_opcode             op;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0)
                no_gaps = $urandom_range(0, 2) == 0;
            if (n % 75 == 74)
                wait_drained();
            create_weight = live_slots > 768 ? 20 : 40;
            r = $urandom_range(0, 99);
            if (r < create_weight)
                op = OP_CREATE;
            else if (r < 70)
                op = OP_DESTROY;
            else if (r < 95)
                op = OP_QUERY;
            else
                op = any_opcode();
            pick_handle(idx, gen);
            issue_op(op, idx, gen);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        logic [IN_IDX_W-1:0] idx;
        logic [GEN_W-1:0]    gen;
        for (int n = 0; n < 6; n++) begin
            pick_handle(idx, gen);
            issue_op(any_opcode(), idx, gen);
        end
        wait_drained();
        issue_op(OP_CREATE, 12'd0, 32'd0);
        pick_handle(idx, gen);
        issue_op(OP_QUERY, idx, gen);
    endtask

    task automatic check_field(input string name, input logic [GEN_W-1:0] want,
                               input logic [GEN_W-1:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    // Compares every result transaction with the oldest awaited reply.
    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                $error("result transaction arrived with no reply awaited");
                mismatches++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("out_index", GEN_W'(want.out_index),
                            GEN_W'(m_axis_tdata[9:0]));
                check_field("out_generation", want.out_gen, m_axis_tdata[41:10]);
                check_field("handle_alive", GEN_W'(want.alive),
                            GEN_W'(m_axis_tdata[42]));
                check_field("status", GEN_W'(want.status),
                            GEN_W'(m_axis_tdata[44:43]));
                check_field("live_count", GEN_W'(want.live_count),
                            GEN_W'(m_axis_tdata[55:45]));
            end
        end
    end

    // Receiver: stalls a random number of cycles before each result, with calm
    // stretches where it is always ready.
    initial begin
        int stall;
        int taken;
        taken = 0;
        m_axis_tready <= 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
            if (taken % 120 == 0)
                rx_calm = $urandom_range(0, 2) == 0;
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side is a hang.
    always @(posedge i_clk) begin
        if (running) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        quiet_cycles  <= 0;
        mismatches    = 0;
        no_gaps       = 1'b0;
        rx_calm       = 1'b0;
        running       = 1'b0;
        recycle_depth = 0;
        fresh_mark    = 0;
        live_slots    = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_gen[i]      = '0;
            slot_live[i]     = 1'b0;
            recycle_stack[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_table_full();
        test_random_ops();
        test_drain_pause();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        running = 1'b0;
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
